// ===== rtl/core/mnva_pkg.sv =====
// ----------------------------------------------------------------------------
// MIDI note voice allocator package
// Shared constants and types: status byte codes, parse modes, running status,
// sequencer states, scan targets and write kinds.
// ----------------------------------------------------------------------------
package mnva_pkg;

  // Default number of voices in the table.
  localparam int unsigned VoicesDefault = 8;

  // Status byte decoding.
  localparam logic [7:0] StatusFlag    = 8'h80;
  localparam logic [7:0] StatusHiMask  = 8'hF0;
  localparam logic [7:0] StatusNoteOff = 8'h80;
  localparam logic [7:0] StatusNoteOn  = 8'h90;
  localparam logic [7:0] VelocityOff   = 8'h00;
  localparam logic [7:0] PitchFree     = 8'h00;

  // Parse mode, one-hot.
  typedef enum logic [4:0] {
    PmRest     = 5'b00001,
    PmPitchOn  = 5'b00010,
    PmVelOn    = 5'b00100,
    PmPitchOff = 5'b01000,
    PmVelOff   = 5'b10000
  } mode_e;

  // Running status.
  typedef enum logic [1:0] {
    RsNone    = 2'd0,
    RsNoteOff = 2'd1,
    RsNoteOn  = 2'd2
  } rs_e;

  // Sequencer state, one-hot.
  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StScan  = 3'b010,
    StWrite = 3'b100
  } seq_e;

  // What the voice walk is looking for.
  typedef enum logic [1:0] {
    ScanFirstPitch = 2'd0,
    ScanLastPitch  = 2'd1,
    ScanFirstVel0  = 2'd2
  } scan_e;

  // Which field of a voice a table write updates.
  typedef enum logic {
    WkPitch    = 1'b0,
    WkVelocity = 1'b1
  } write_kind_e;

endpackage

// ===== rtl/core/midi_note_voice_allocator_top.sv =====
// ----------------------------------------------------------------------------
// MIDI note voice allocator
// Parses received MIDI bytes and keeps a polyphonic table of voice pitches
// and velocities, reporting every table write as one output transaction.
// ----------------------------------------------------------------------------
// The block takes one received MIDI byte per input transaction and handles
// note-on and note-off messages, with running status, on any channel. It
// keeps a table of VOICES voices (pitch and velocity each), cleared at reset,
// and every write into that table leaves as one output transaction carrying
// the voice index, the kind of write and the voice's pitch and velocity after
// the write. A velocity byte is taken, then the write is made. A pitch byte,
// and a note-on status byte, walk the voice table one voice per cycle through
// a single shared comparator; a walk for the first match ends early. A write
// waits for the output register to be free, so a stalled output holds the
// block at that point. The input stall is low exactly when the sequencer
// is idle.
// ----------------------------------------------------------------------------
module midi_note_voice_allocator_top #(
  parameter int unsigned VOICES = mnva_pkg::VoicesDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Input channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  // Output channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] voice_index_o,
  output logic       write_kind_o,
  output logic [7:0] voice_pitch_o,
  output logic [7:0] voice_velocity_o
);

  localparam int unsigned IW = $clog2(VOICES);
  localparam logic [IW-1:0] LastVoice = IW'(VOICES - 1);

  // Control state.
  mnva_pkg::seq_e  state_q;
  mnva_pkg::mode_e mode_q;
  mnva_pkg::rs_e   rs_q;
  mnva_pkg::scan_e scan_q;
  logic [IW-1:0]   chosen_q;
  logic [IW-1:0]   idx_q;
  logic [IW-1:0]   fresh_q;
  logic            use_fresh_q;
  logic            out_valid_q;

  // Working payload.
  logic [7:0]              byte_q;
  mnva_pkg::write_kind_e   wk_q;
  logic [7:0]              wval_q;

  // Voice table: one read port and one write port, both at idx_q.
  logic [7:0] pitch_q [VOICES];
  logic [7:0] vel_q   [VOICES];

  // Output register.
  logic [2:0] out_idx_q;
  logic       out_wk_q;
  logic [7:0] out_pitch_q;
  logic [7:0] out_vel_q;

  logic [7:0]    rd_pitch;
  logic [7:0]    rd_vel;
  logic          is_last;
  logic          pitch_hit;
  logic [IW-1:0] fresh_n;
  logic          in_acc;
  logic          out_free;
  logic          wr_en;

  assign in_stall_o = (state_q != mnva_pkg::StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;

  // The shared comparator looks at the voice the index points to.
  assign rd_pitch  = pitch_q[idx_q];
  assign rd_vel    = vel_q[idx_q];
  assign is_last   = (idx_q == LastVoice);
  assign pitch_hit = (rd_pitch == byte_q);
  // The last free voice seen so far, this one included.
  assign fresh_n   = (rd_pitch == mnva_pkg::PitchFree) ? idx_q : fresh_q;

  // A write is made only once the output register can take its result.
  assign out_free = !out_valid_q || !out_stall_i;
  assign wr_en    = (state_q == mnva_pkg::StWrite) && out_free;

  // Sequencer and parser.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mnva_pkg::StIdle;
      mode_q      <= mnva_pkg::PmRest;
      rs_q        <= mnva_pkg::RsNone;
      scan_q      <= mnva_pkg::ScanFirstPitch;
      chosen_q    <= '0;
      idx_q       <= '0;
      fresh_q     <= '0;
      use_fresh_q <= 1'b0;
    end else begin
      case (state_q)
        mnva_pkg::StIdle: begin
          if (in_acc) begin
            idx_q   <= '0;
            fresh_q <= '0;
            case (mode_q)
              mnva_pkg::PmPitchOn: begin
                // Reuse a voice holding this pitch, else fill the chosen one.
                mode_q      <= mnva_pkg::PmVelOn;
                scan_q      <= mnva_pkg::ScanFirstPitch;
                use_fresh_q <= 1'b0;
                state_q     <= mnva_pkg::StScan;
              end
              mnva_pkg::PmPitchOff: begin
                mode_q  <= mnva_pkg::PmVelOff;
                scan_q  <= mnva_pkg::ScanLastPitch;
                state_q <= mnva_pkg::StScan;
              end
              mnva_pkg::PmVelOn, mnva_pkg::PmVelOff: begin
                // Velocity goes straight to the chosen voice; note off
                // always writes zero, whatever byte arrived.
                mode_q  <= mnva_pkg::PmRest;
                idx_q   <= chosen_q;
                wk_q    <= mnva_pkg::WkVelocity;
                wval_q  <= (mode_q == mnva_pkg::PmVelOn) ? rx_byte_i
                                                          : mnva_pkg::VelocityOff;
                state_q <= mnva_pkg::StWrite;
              end
              default: begin
                mode_q <= mnva_pkg::PmRest;
                if (rx_byte_i >= mnva_pkg::StatusFlag) begin
                  if ((rx_byte_i & mnva_pkg::StatusHiMask) == mnva_pkg::StatusNoteOff) begin
                    rs_q   <= mnva_pkg::RsNoteOff;
                    mode_q <= mnva_pkg::PmPitchOff;
                  end else if ((rx_byte_i & mnva_pkg::StatusHiMask) ==
                               mnva_pkg::StatusNoteOn) begin
                    // Look for a silent voice; with none, stay at rest.
                    rs_q    <= mnva_pkg::RsNoteOn;
                    scan_q  <= mnva_pkg::ScanFirstVel0;
                    state_q <= mnva_pkg::StScan;
                  end else begin
                    rs_q <= mnva_pkg::RsNone;
                  end
                end else begin
                  case (rs_q)
                    mnva_pkg::RsNoteOff: begin
                      mode_q  <= mnva_pkg::PmVelOff;
                      scan_q  <= mnva_pkg::ScanLastPitch;
                      state_q <= mnva_pkg::StScan;
                    end
                    mnva_pkg::RsNoteOn: begin
                      // Running-status note on reuses a voice holding this pitch, else allocates the last free voice.
                      mode_q      <= mnva_pkg::PmVelOn;
                      scan_q      <= mnva_pkg::ScanFirstPitch;
                      use_fresh_q <= 1'b1;
                      state_q     <= mnva_pkg::StScan;
                    end
                    default: begin
                    end
                  endcase
                end
              end
            endcase
          end
        end
        mnva_pkg::StScan: begin
          fresh_q <= fresh_n;
          idx_q   <= idx_q + IW'(1);
          case (scan_q)
            mnva_pkg::ScanFirstPitch: begin
              if (pitch_hit) begin
                chosen_q <= idx_q;
                state_q  <= mnva_pkg::StIdle;
              end else if (is_last) begin
                wk_q    <= mnva_pkg::WkPitch;
                wval_q  <= byte_q;
                state_q <= mnva_pkg::StWrite;
                if (use_fresh_q) begin
                  chosen_q <= fresh_n;
                  idx_q    <= fresh_n;
                end else begin
                  idx_q <= chosen_q;
                end
              end
            end
            mnva_pkg::ScanLastPitch: begin
              if (pitch_hit) begin
                chosen_q <= idx_q;
              end
              if (is_last) begin
                state_q <= mnva_pkg::StIdle;
              end
            end
            default: begin
              if (rd_vel == mnva_pkg::VelocityOff) begin
                chosen_q <= idx_q;
                mode_q   <= mnva_pkg::PmPitchOn;
                state_q  <= mnva_pkg::StIdle;
              end else if (is_last) begin
                state_q <= mnva_pkg::StIdle;
              end
            end
          endcase
        end
        mnva_pkg::StWrite: begin
          if (out_free) begin
            state_q <= mnva_pkg::StIdle;
          end
        end
        default: begin
          state_q <= mnva_pkg::StIdle;
        end
      endcase
    end
  end

  // Byte latch, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byte_q <= rx_byte_i;
    end
  end

  // Voice table, cleared at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned v = 0; v < VOICES; v++) begin
        pitch_q[v] <= mnva_pkg::PitchFree;
        vel_q[v]   <= mnva_pkg::VelocityOff;
      end
    end else if (wr_en) begin
      if (wk_q == mnva_pkg::WkPitch) begin
        pitch_q[idx_q] <= wval_q;
      end else begin
        vel_q[idx_q] <= wval_q;
      end
    end
  end

  // Output register: loaded with the voice as it stands after the write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (wr_en) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      out_idx_q   <= 3'(idx_q);
      out_wk_q    <= wk_q;
      out_pitch_q <= (wk_q == mnva_pkg::WkPitch) ? wval_q : rd_pitch;
      out_vel_q   <= (wk_q == mnva_pkg::WkVelocity) ? wval_q : rd_vel;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign voice_index_o    = out_idx_q;
  assign write_kind_o     = out_wk_q;
  assign voice_pitch_o    = out_pitch_q;
  assign voice_velocity_o = out_vel_q;

  // A velocity byte goes straight to the write step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (mode_q == mnva_pkg::PmVelOn || mode_q == mnva_pkg::PmVelOff)
    |=> state_q == mnva_pkg::StWrite)
    else $error("velocity byte did not lead to a table write");

  // A pending write waits while the output register is full and stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mnva_pkg::StWrite && out_valid_q && out_stall_i
    |=> state_q == mnva_pkg::StWrite && $stable(out_pitch_q) && $stable(out_vel_q))
    else $error("table write overran a stalled output transaction");

  // Every table write produces an output transaction in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> out_valid_q && !in_stall_o)
    else $error("table write without an output transaction");

  // The walk never leaves the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mnva_pkg::StScan |-> idx_q <= LastVoice)
    else $error("voice walk index out of range");

endmodule
